// ===== rtl/gcof_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcof_pkg
// Shared types and constants of the grid cell occupancy flood fill block.
// ----------------------------------------------------------------------------
package gcof_pkg;

   // default grid limit along one axis
   localparam int unsigned MAX_CELLS_PER_AXIS_DEF = 32;

   // field widths
   localparam int unsigned COORD_W = 6;
   localparam int unsigned INDEX_W = 16;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned CSR_DATA_W = 6;

   // width of linear cell arithmetic: 63^3 stays below 2^18
   localparam int unsigned LIN_W = 18;

   // item kinds
   typedef enum logic [1:0] {
      KIND_MARK_XYZ   = 2'd0,
      KIND_MARK_INDEX = 2'd1,
      KIND_QUERY_XYZ  = 2'd2,
      KIND_QUERY_INDEX = 2'd3
   } kind_type;

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CELLS_X = 2'd0,
      CSR_CELLS_Y = 2'd1,
      CSR_CELLS_Z = 2'd2
   } csr_index_type;

endpackage

// ===== rtl/gcof_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcof channel interfaces
// Valid/ready channels for the mark/query items and the query results.
// ----------------------------------------------------------------------------
interface gcof_req_if import gcof_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [1:0]                 kind;
   logic [COORD_W-1:0]         x;
   logic [COORD_W-1:0]         y;
   logic [COORD_W-1:0]         z;
   logic signed [INDEX_W-1:0]  cell_index;

   modport source (output valid, kind, x, y, z, cell_index, input ready);
   modport sink (input valid, kind, x, y, z, cell_index, output ready);
endinterface

interface gcof_rsp_if ();
   logic valid;
   logic ready;
   logic active;
   logic in_range;

   modport source (output valid, active, in_range, input ready);
   modport sink (input valid, active, in_range, output ready);
endinterface

// ===== rtl/gcof_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcof_ram
// Simple dual-port synchronous memory, one write and one registered read.
// ----------------------------------------------------------------------------
module gcof_ram #(
   parameter int unsigned DEPTH  = 32768,
   parameter int unsigned ADDR_W = 15,
   parameter int unsigned DATA_W = 1
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [DATA_W-1:0] wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [DATA_W-1:0] rdata
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/grid_cell_occupancy_flood_fill.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_cell_occupancy_flood_fill
// 3D cell occupancy map; queries rebuild the map by an exterior flood fill.
// ----------------------------------------------------------------------------
// channel | dir | payload                          | transfer
// req     | in  | kind, x, y, z, cell_index        | valid & ready
// rsp     | out | active, in_range (one per query) | valid & ready
// csr     | in  | csr_index, csr_wdata             | csr_we
//
// a mark passes 2 multiply stages for the index, a range check with a flag
//   read, and a flag write; one out of range goes back without the write
// a query on a valid map reads its flag when in range; a rebuild first scans
//   the boundary cells, then fills from each queued cell to its free neighbors,
//   then sets every flag and clears those of the queued cells, all through
//   the one flag memory
// after reset, a clearing pass zeroes all MAX_CELLS_PER_AXIS^3 flags
// a result waits in the output register; a new item is taken meanwhile, and
//   the block stalls only when a second result is ready before the first left
// ----------------------------------------------------------------------------
module grid_cell_occupancy_flood_fill import gcof_pkg::*; #(
   parameter int unsigned MAX_CELLS_PER_AXIS = MAX_CELLS_PER_AXIS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   gcof_req_if.sink              req,
   gcof_rsp_if.source            rsp,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int unsigned DEPTH = MAX_CELLS_PER_AXIS * MAX_CELLS_PER_AXIS
                                   * MAX_CELLS_PER_AXIS;
   localparam int unsigned CW = $clog2(DEPTH);
   localparam int unsigned LIM = (MAX_CELLS_PER_AXIS < 63) ? MAX_CELLS_PER_AXIS : 63;

   typedef enum logic [17:0] {
      S_CLEAR     = 18'h00001,
      S_IDLE      = 18'h00002,
      S_CALC1     = 18'h00004,
      S_CALC2     = 18'h00008,
      S_DECIDE    = 18'h00010,
      S_MARK_CHK  = 18'h00020,
      S_SEED_RD   = 18'h00040,
      S_SEED_CHK  = 18'h00080,
      S_FILL_NEXT = 18'h00100,
      S_POP_WAIT  = 18'h00200,
      S_NB_RD     = 18'h00400,
      S_NB_CHK    = 18'h00800,
      S_SET_ALL   = 18'h01000,
      S_ZERO_RD   = 18'h02000,
      S_ZERO_WR   = 18'h04000,
      S_QUERY     = 18'h08000,
      S_Q_CHK     = 18'h10000,
      S_OUT       = 18'h20000
   } state_type;

   state_type state_ff, state_in;

   logic [CSR_DATA_W-1:0] cells_x_ff, cells_x_in;
   logic [CSR_DATA_W-1:0] cells_y_ff, cells_y_in;
   logic [CSR_DATA_W-1:0] cells_z_ff, cells_z_in;

   logic [1:0]         kind_ff, kind_in;
   logic [COORD_W-1:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic [INDEX_W-1:0] raw_ff, raw_in;
   logic [COORD_W-1:0] ax_ff, ax_in, ay_ff, ay_in, az_ff, az_in;
   logic [LIN_W-1:0]   plane_ff, plane_in, t_ff, t_in, nc_ff, nc_in, lin_ff, lin_in;
   logic               xyz_ok_ff, xyz_ok_in, ok_ff, ok_in;
   logic [LIN_W-1:0]   c_ff, c_in;
   logic               map_valid_ff, map_valid_in;
   logic [LIN_W-1:0]   head_ff, head_in, tail_ff, tail_in, cnt_ff, cnt_in;
   logic [COORD_W-1:0] sx_ff, sx_in, sy_ff, sy_in, sz_ff, sz_in;
   logic [LIN_W-1:0]   cur_ff, cur_in, nb_addr_ff, nb_addr_in;
   logic [2:0]         nb_ff, nb_in;
   logic [CW-1:0]      clr_ff, clr_in;
   logic               res_active_ff, res_active_in, res_range_ff, res_range_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_active_ff, rsp_active_in, rsp_range_ff, rsp_range_in;

   // memory ports
   logic          flag_we, flag_wdata, flag_rdata;
   logic [CW-1:0] flag_waddr, flag_raddr;
   logic          q_we;
   logic [CW-1:0] q_waddr, q_wdata, q_raddr, q_rdata;

   // scratch
   logic [COORD_W-1:0] ax_lim, ay_lim, az_lim;
   logic               seed_adv, seed_last, boundary, ok_now;
   logic [LIN_W-1:0]   step;
   logic [LIN_W:0]     nb_sum;
   logic               rsp_load;

   gcof_ram #(.DEPTH(DEPTH), .ADDR_W(CW), .DATA_W(1)) u_flags (
      .clock (clock),
      .we    (flag_we),
      .waddr (flag_waddr),
      .wdata (flag_wdata),
      .raddr (flag_raddr),
      .rdata (flag_rdata)
   );

   gcof_ram #(.DEPTH(DEPTH), .ADDR_W(CW), .DATA_W(CW)) u_queue (
      .clock (clock),
      .we    (q_we),
      .waddr (q_waddr),
      .wdata (q_wdata),
      .raddr (q_raddr),
      .rdata (q_rdata)
   );

   // axis sizes clamped to the grid limit
   always_comb begin
      ax_lim = (cells_x_ff > COORD_W'(LIM)) ? COORD_W'(LIM) : cells_x_ff;
      ay_lim = (cells_y_ff > COORD_W'(LIM)) ? COORD_W'(LIM) : cells_y_ff;
      az_lim = (cells_z_ff > COORD_W'(LIM)) ? COORD_W'(LIM) : cells_z_ff;
   end

   // register writes
   always_comb begin
      cells_x_in = cells_x_ff;
      cells_y_in = cells_y_ff;
      cells_z_in = cells_z_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_CELLS_X: cells_x_in = csr_wdata;
            CSR_CELLS_Y: cells_y_in = csr_wdata;
            CSR_CELLS_Z: cells_z_in = csr_wdata;
            default: ;
         endcase
      end
   end

   assign req.ready = (state_ff == S_IDLE);
   assign rsp.valid = rsp_valid_ff;
   assign rsp.active = rsp_active_ff;
   assign rsp.in_range = rsp_range_ff;

   // boundary scan helpers
   assign boundary = (sx_ff == '0) || (sy_ff == '0) || (sz_ff == '0)
                     || (sx_ff == ax_ff - 1'b1) || (sy_ff == ay_ff - 1'b1)
                     || (sz_ff == az_ff - 1'b1);
   assign seed_last = (sx_ff == ax_ff - 1'b1) && (sy_ff == ay_ff - 1'b1)
                      && (sz_ff == az_ff - 1'b1);

   // neighbor stride and candidate
   always_comb begin
      case (nb_ff[2:1])
         2'd0:    step = LIN_W'(1);
         2'd1:    step = LIN_W'(ax_ff);
         default: step = plane_ff;
      endcase
      nb_sum = {1'b0, cur_ff} + {1'b0, step};
   end

   // main sequencer
   always_comb begin
      state_in = state_ff;
      kind_in = kind_ff;
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      raw_in = raw_ff;
      ax_in = ax_ff;
      ay_in = ay_ff;
      az_in = az_ff;
      plane_in = plane_ff;
      t_in = t_ff;
      nc_in = nc_ff;
      lin_in = lin_ff;
      xyz_ok_in = xyz_ok_ff;
      ok_in = ok_ff;
      c_in = c_ff;
      map_valid_in = map_valid_ff;
      head_in = head_ff;
      tail_in = tail_ff;
      cnt_in = cnt_ff;
      sx_in = sx_ff;
      sy_in = sy_ff;
      sz_in = sz_ff;
      cur_in = cur_ff;
      nb_addr_in = nb_addr_ff;
      nb_in = nb_ff;
      clr_in = clr_ff;
      res_active_in = res_active_ff;
      res_range_in = res_range_ff;
      flag_we = 1'b0;
      flag_waddr = CW'(c_ff);
      flag_wdata = 1'b1;
      flag_raddr = CW'(c_ff);
      q_we = 1'b0;
      q_waddr = CW'(tail_ff);
      q_wdata = CW'(cnt_ff);
      q_raddr = CW'(head_ff);
      seed_adv = 1'b0;
      ok_now = 1'b0;
      rsp_load = 1'b0;

      unique case (state_ff)
         // zero every flag after reset
         S_CLEAR: begin
            flag_we = 1'b1;
            flag_waddr = clr_ff;
            flag_wdata = 1'b0;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == CW'(DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         // take an item
         S_IDLE: begin
            if (req.valid) begin
               kind_in = req.kind;
               x_in = req.x;
               y_in = req.y;
               z_in = req.z;
               raw_in = req.cell_index;
               ax_in = ax_lim;
               ay_in = ay_lim;
               az_in = az_lim;
               state_in = S_CALC1;
            end
         end
         // first multiply stage
         S_CALC1: begin
            plane_in = LIN_W'(ax_ff) * LIN_W'(ay_ff);
            t_in = LIN_W'(ay_ff) * LIN_W'(z_ff) + LIN_W'(y_ff);
            xyz_ok_in = (x_ff < ax_ff) && (y_ff < ay_ff) && (z_ff < az_ff);
            state_in = S_CALC2;
         end
         // second multiply stage
         S_CALC2: begin
            nc_in = plane_ff * LIN_W'(az_ff);
            lin_in = LIN_W'(x_ff) + LIN_W'(ax_ff) * t_ff;
            state_in = S_DECIDE;
         end
         // range check and dispatch
         S_DECIDE: begin
            if ((kind_ff == KIND_MARK_XYZ) || (kind_ff == KIND_QUERY_XYZ)) begin
               ok_now = xyz_ok_ff;
               c_in = lin_ff;
            end else begin
               ok_now = !raw_ff[INDEX_W-1] && (LIN_W'(raw_ff) < nc_ff);
               c_in = LIN_W'(raw_ff);
            end
            ok_in = ok_now;
            flag_raddr = CW'(c_in);
            if ((kind_ff == KIND_MARK_XYZ) || (kind_ff == KIND_MARK_INDEX)) begin
               state_in = ok_now ? S_MARK_CHK : S_IDLE;
            end else if ((kind_ff == KIND_QUERY_INDEX || ok_now) && !map_valid_ff) begin
               head_in = '0;
               tail_in = '0;
               cnt_in = '0;
               sx_in = '0;
               sy_in = '0;
               sz_in = '0;
               if (nc_ff == '0) begin
                  map_valid_in = 1'b1;
                  state_in = S_QUERY;
               end else begin
                  state_in = S_SEED_RD;
               end
            end else begin
               state_in = S_QUERY;
            end
         end
         // set the flag, a fresh mark invalidates the map
         S_MARK_CHK: begin
            if (!flag_rdata) begin
               flag_we = 1'b1;
               map_valid_in = 1'b0;
            end
            state_in = S_IDLE;
         end
         // boundary scan: read flag of a boundary cell
         S_SEED_RD: begin
            flag_raddr = CW'(cnt_ff);
            if (boundary) begin
               state_in = S_SEED_CHK;
            end else begin
               seed_adv = 1'b1;
            end
         end
         // boundary scan: enqueue a free cell
         S_SEED_CHK: begin
            if (!flag_rdata) begin
               flag_we = 1'b1;
               flag_waddr = CW'(cnt_ff);
               q_we = 1'b1;
               tail_in = tail_ff + 1'b1;
            end
            seed_adv = 1'b1;
         end
         // pop the next queued cell or finish the fill
         S_FILL_NEXT: begin
            if (head_ff < tail_ff) begin
               head_in = head_ff + 1'b1;
               state_in = S_POP_WAIT;
            end else begin
               cnt_in = '0;
               state_in = S_SET_ALL;
            end
         end
         S_POP_WAIT: begin
            cur_in = LIN_W'(q_rdata);
            nb_in = '0;
            state_in = S_NB_RD;
         end
         // neighbor: bounds check and flag read
         S_NB_RD: begin
            if (nb_ff == 3'd6) begin
               state_in = S_FILL_NEXT;
            end else if (!nb_ff[0]) begin
               nb_addr_in = cur_ff - step;
               flag_raddr = CW'(nb_addr_in);
               if (cur_ff >= step) begin
                  state_in = S_NB_CHK;
               end else begin
                  nb_in = nb_ff + 1'b1;
               end
            end else begin
               nb_addr_in = nb_sum[LIN_W-1:0];
               flag_raddr = CW'(nb_addr_in);
               if (nb_sum < {1'b0, nc_ff}) begin
                  state_in = S_NB_CHK;
               end else begin
                  nb_in = nb_ff + 1'b1;
               end
            end
         end
         // neighbor: enqueue if free
         S_NB_CHK: begin
            if (!flag_rdata) begin
               flag_we = 1'b1;
               flag_waddr = CW'(nb_addr_ff);
               q_we = 1'b1;
               q_wdata = CW'(nb_addr_ff);
               tail_in = tail_ff + 1'b1;
            end
            nb_in = nb_ff + 1'b1;
            state_in = S_NB_RD;
         end
         // every cell becomes active
         S_SET_ALL: begin
            flag_we = 1'b1;
            flag_waddr = CW'(cnt_ff);
            if (cnt_ff == nc_ff - 1'b1) begin
               cnt_in = '0;
               if (tail_ff == '0) begin
                  map_valid_in = 1'b1;
                  state_in = S_QUERY;
               end else begin
                  state_in = S_ZERO_RD;
               end
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         // cells reached from outside become inactive
         S_ZERO_RD: begin
            q_raddr = CW'(cnt_ff);
            cnt_in = cnt_ff + 1'b1;
            state_in = S_ZERO_WR;
         end
         S_ZERO_WR: begin
            flag_we = 1'b1;
            flag_waddr = q_rdata;
            flag_wdata = 1'b0;
            if (cnt_ff == tail_ff) begin
               map_valid_in = 1'b1;
               state_in = S_QUERY;
            end else begin
               state_in = S_ZERO_RD;
            end
         end
         // query read
         S_QUERY: begin
            if (ok_ff) begin
               state_in = S_Q_CHK;
            end else begin
               res_active_in = 1'b0;
               res_range_in = 1'b0;
               state_in = S_OUT;
            end
         end
         S_Q_CHK: begin
            res_active_in = flag_rdata;
            res_range_in = 1'b1;
            state_in = S_OUT;
         end
         // hand the result to the output register
         S_OUT: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // step the boundary scan
      if (seed_adv) begin
         if (seed_last) begin
            state_in = S_FILL_NEXT;
         end else begin
            cnt_in = cnt_ff + 1'b1;
            state_in = S_SEED_RD;
            if (sx_ff == ax_ff - 1'b1) begin
               sx_in = '0;
               if (sy_ff == ay_ff - 1'b1) begin
                  sy_in = '0;
                  sz_in = sz_ff + 1'b1;
               end else begin
                  sy_in = sy_ff + 1'b1;
               end
            end else begin
               sx_in = sx_ff + 1'b1;
            end
         end
      end
   end

   // output register
   always_comb begin
      rsp_active_in = rsp_active_ff;
      rsp_range_in = rsp_range_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_active_in = res_active_ff;
         rsp_range_in = res_range_ff;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         cells_x_ff <= CSR_DATA_W'(1);
         cells_y_ff <= CSR_DATA_W'(1);
         cells_z_ff <= CSR_DATA_W'(1);
         map_valid_ff <= 1'b0;
         head_ff <= '0;
         tail_ff <= '0;
         clr_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cells_x_ff <= cells_x_in;
         cells_y_ff <= cells_y_in;
         cells_z_ff <= cells_z_in;
         map_valid_ff <= map_valid_in;
         head_ff <= head_in;
         tail_ff <= tail_in;
         clr_ff <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
      raw_ff <= raw_in;
      ax_ff <= ax_in;
      ay_ff <= ay_in;
      az_ff <= az_in;
      plane_ff <= plane_in;
      t_ff <= t_in;
      nc_ff <= nc_in;
      lin_ff <= lin_in;
      xyz_ok_ff <= xyz_ok_in;
      ok_ff <= ok_in;
      c_ff <= c_in;
      cnt_ff <= cnt_in;
      sx_ff <= sx_in;
      sy_ff <= sy_in;
      sz_ff <= sz_in;
      cur_ff <= cur_in;
      nb_addr_ff <= nb_addr_in;
      nb_ff <= nb_in;
      res_active_ff <= res_active_in;
      res_range_ff <= res_range_in;
      rsp_active_ff <= rsp_active_in;
      rsp_range_ff <= rsp_range_in;
   end

   // queue pointers stay ordered
   a_head_le_tail: assert property (@(posedge clock) disable iff (reset)
      head_ff <= tail_ff)
      else $error("fill queue head passed tail");

   // a fresh mark drops the map
   a_mark_invalidates: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MARK_CHK && !flag_rdata) |=> !map_valid_ff)
      else $error("mark of a free cell left the map valid");

   // a result is loaded only after a query went through the sequencer
   a_load_from_out: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff)) |-> $past(state_ff == S_OUT))
      else $error("result appeared outside the output step");

   // a query result always finds a rebuilt map when in range
   a_query_map_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_Q_CHK) |-> map_valid_ff)
      else $error("in-range query read an invalid map");

endmodule

// ===== bench/tb_grid_cell_occupancy_flood_fill.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_grid_cell_occupancy_flood_fill
// Drives mark and query items through the occupancy flood fill block over a
// series of grid sizes and idle patterns. A behavioral occupancy map with its
// own exterior fill predicts each query result not typed in a directed row; every
// result transfer is compared field by field against the oldest pending one.
// ----------------------------------------------------------------------------
module tb_grid_cell_occupancy_flood_fill;
   import gcof_pkg::*;

   localparam int unsigned AXIS_MAX = 32;
   localparam int unsigned CELL_MAX = AXIS_MAX * AXIS_MAX * AXIS_MAX;
   localparam int unsigned CYCLE_LIMIT = 6000000;
   localparam int unsigned SETTLE_CYCLES = 40;

   typedef struct {
      kind_type           kind;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] z;
      logic [INDEX_W-1:0] idx;
      bit                 known;
      bit                 k_active;
      bit                 k_in_range;
   } cell_item_type;

   typedef struct {
      bit active;
      bit in_range;
   } query_result_type;

   typedef struct {
      int unsigned sx;
      int unsigned sy;
      int unsigned sz;
      int unsigned count;
      int unsigned send_idle;
      int unsigned recv_stall;
      int unsigned hold_cycles;
      bit          mid_drain;
   } phase_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_CELLS_X;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   gcof_req_if req_ch ();
   gcof_rsp_if rsp_ch ();

   grid_cell_occupancy_flood_fill u_top (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // shadow occupancy map
   bit          occ_bits [CELL_MAX];
   int unsigned fill_cells [CELL_MAX];
   bit          occ_map_ok;
   int unsigned reg_x, reg_y, reg_z;

   query_result_type pending_results [$];
   int unsigned   error_count = 0;
   int unsigned   cycle_count = 0;
   int unsigned   send_idle_pct = 0;
   int unsigned   recv_stall_pct = 0;
   int unsigned   hold_left = 0;
   int unsigned   hold_len = 0;
   int unsigned   hold_seq = 0;
   int unsigned   hold_seen = 0;

   always #5 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic int unsigned axis_len(int unsigned r);
      return (r > AXIS_MAX) ? AXIS_MAX : r;
   endfunction

   function automatic void claim_cell(int unsigned c, inout int unsigned tail);
      if (!occ_bits[c] && tail < CELL_MAX) begin
         occ_bits[c] = 1'b1;
         fill_cells[tail] = c;
         tail++;
      end
   endfunction

   // exterior fill from the unmarked boundary, six linear neighbors
   function automatic void refill_map();
      int unsigned ex, ey, ez, nc, head, tail, c;
      int unsigned stride [3];
      ex = axis_len(reg_x);
      ey = axis_len(reg_y);
      ez = axis_len(reg_z);
      nc = ex * ey * ez;
      head = 0;
      tail = 0;
      for (int unsigned k = 0; k < ez; k++)
         for (int unsigned j = 0; j < ey; j++)
            for (int unsigned i = 0; i < ex; i++)
               if (i == 0 || j == 0 || k == 0 || i == ex - 1 || j == ey - 1 || k == ez - 1)
                  claim_cell(i + ex * (j + ey * k), tail);
      stride[0] = 1;
      stride[1] = ex;
      stride[2] = ex * ey;
      while (head < tail) begin
         c = fill_cells[head];
         head++;
         for (int b = 0; b < 3; b++) begin
            if (c >= stride[b]) claim_cell(c - stride[b], tail);
            if (c + stride[b] < nc) claim_cell(c + stride[b], tail);
         end
      end
      for (int unsigned n = 0; n < nc; n++) occ_bits[n] = 1'b1;
      for (int unsigned n = 0; n < tail; n++) occ_bits[fill_cells[n]] = 1'b0;
      occ_map_ok = 1'b1;
   endfunction

   // apply one accepted item; returns 1 when it yields a result
   function automatic bit apply_item(cell_item_type it, output query_result_type res);
      int unsigned ex, ey, ez, nc, c;
      bit ok;
      ex = axis_len(reg_x);
      ey = axis_len(reg_y);
      ez = axis_len(reg_z);
      nc = ex * ey * ez;
      res = '{0, 0};
      if (it.kind == KIND_MARK_XYZ || it.kind == KIND_QUERY_XYZ) begin
         ok = it.x < ex && it.y < ey && it.z < ez;
         c = ok ? it.x + ex * (it.y + ey * it.z) : 0;
      end else begin
         ok = !it.idx[INDEX_W-1] && it.idx < nc;
         c = ok ? it.idx : 0;
      end
      if (it.kind == KIND_MARK_XYZ || it.kind == KIND_MARK_INDEX) begin
         if (ok && !occ_bits[c]) begin
            occ_bits[c] = 1'b1;
            occ_map_ok = 1'b0;
         end
         return 1'b0;
      end
      if ((it.kind == KIND_QUERY_INDEX || ok) && !occ_map_ok) refill_map();
      res.active = ok ? occ_bits[c] : 1'b0;
      res.in_range = ok;
      return 1'b1;
   endfunction

   // receiver: random stall plus an optional long hold-off
   always @(negedge clock) begin
      if (hold_seq != hold_seen) begin
         hold_seen <= hold_seq;
         hold_left <= hold_len;
         rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // result check at each transfer
   always @(posedge clock) begin
      query_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_results.size() == 0) begin
            error_count++;
            if (error_count <= 10)
               $display("unexpected result: active %0b in_range %0b",
                        rsp_ch.active, rsp_ch.in_range);
         end else begin
            want = pending_results.pop_front();
            if (rsp_ch.active !== want.active || rsp_ch.in_range !== want.in_range) begin
               error_count++;
               if (error_count <= 10)
                  $display("result mismatch: expected active %0b in_range %0b, got %0b %0b",
                           want.active, want.in_range, rsp_ch.active, rsp_ch.in_range);
            end
         end
      end
   end

   // offer one item from a falling edge; returns at the falling edge after transfer
   task automatic offer_item(cell_item_type it);
      query_result_type res;
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.kind <= it.kind;
      req_ch.x <= it.x;
      req_ch.y <= it.y;
      req_ch.z <= it.z;
      req_ch.cell_index <= it.idx;
      do @(posedge clock); while (!req_ch.ready);
      if (apply_item(it, res)) begin
         if (it.known) res = '{it.k_active, it.k_in_range};
         pending_results = {pending_results, res};
      end
      @(negedge clock);
   endtask

   // wait at a falling edge until every result has arrived, then settle
   task automatic drain_results();
      req_ch.valid <= 1'b0;
      @(negedge clock);
      while (pending_results.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_sizes(int unsigned sx, int unsigned sy, int unsigned sz);
      csr_we <= 1'b1;
      csr_index <= CSR_CELLS_X;
      csr_wdata <= sx[CSR_DATA_W-1:0];
      @(negedge clock);
      csr_index <= CSR_CELLS_Y;
      csr_wdata <= sy[CSR_DATA_W-1:0];
      @(negedge clock);
      csr_index <= CSR_CELLS_Z;
      csr_wdata <= sz[CSR_DATA_W-1:0];
      @(negedge clock);
      csr_we <= 1'b0;
      reg_x = sx;
      reg_y = sy;
      reg_z = sz;
   endtask

   function automatic logic [COORD_W-1:0] pick_coord(int unsigned len);
      if (len > 0 && $urandom_range(99) < 88) return COORD_W'($urandom_range(len - 1));
      return COORD_W'($urandom_range(63));
   endfunction

   // mostly in-range marks and queries, with out-of-range noise
   function automatic cell_item_type random_item();
      cell_item_type it;
      int unsigned roll, nc;
      nc = axis_len(reg_x) * axis_len(reg_y) * axis_len(reg_z);
      roll = $urandom_range(99);
      it.kind = (roll < 35) ? KIND_MARK_XYZ : (roll < 58) ? KIND_MARK_INDEX :
                (roll < 80) ? KIND_QUERY_XYZ : KIND_QUERY_INDEX;
      it.x = pick_coord(axis_len(reg_x));
      it.y = pick_coord(axis_len(reg_y));
      it.z = pick_coord(axis_len(reg_z));
      if (nc > 0 && $urandom_range(99) < 85) it.idx = INDEX_W'($urandom_range(nc - 1));
      else it.idx = INDEX_W'($urandom_range(16'hFFFF));
      it.known = 1'b0;
      it.k_active = 1'b0;
      it.k_in_range = 1'b0;
      return it;
   endfunction

   // directed rows on a 3x3x3 grid; typed results where obvious
   cell_item_type directed_rows [] = '{
      '{KIND_QUERY_XYZ,   1,  1,  1, 16'd0,    1, 0, 1},
      '{KIND_QUERY_XYZ,  63, 63, 63, 16'd0,    1, 0, 0},
      '{KIND_QUERY_INDEX, 0,  0,  0, 16'hFFFF, 1, 0, 0},
      '{KIND_QUERY_INDEX, 0,  0,  0, 16'h7FFF, 1, 0, 0},
      '{KIND_QUERY_INDEX, 0,  0,  0, 16'h8000, 1, 0, 0},
      '{KIND_MARK_XYZ,   63,  0,  0, 16'd0,    0, 0, 0},
      '{KIND_MARK_INDEX,  0,  0,  0, 16'hFFFF, 0, 0, 0},
      '{KIND_MARK_INDEX,  0,  0,  0, 16'd27,   0, 0, 0},
      '{KIND_MARK_INDEX,  0,  0,  0, 16'd4,    0, 0, 0},
      '{KIND_MARK_INDEX,  0,  0,  0, 16'd10,   0, 0, 0},
      '{KIND_MARK_INDEX,  0,  0,  0, 16'd12,   0, 0, 0},
      '{KIND_MARK_INDEX,  0,  0,  0, 16'd14,   0, 0, 0},
      '{KIND_MARK_INDEX,  0,  0,  0, 16'd16,   0, 0, 0},
      '{KIND_MARK_INDEX,  0,  0,  0, 16'd22,   0, 0, 0},
      '{KIND_QUERY_INDEX, 0,  0,  0, 16'd13,   1, 1, 1},
      '{KIND_QUERY_XYZ,   1,  1,  1, 16'd0,    1, 1, 1},
      '{KIND_QUERY_XYZ,   0,  0,  0, 16'd0,    1, 0, 1},
      '{KIND_MARK_XYZ,    2,  2,  2, 16'd0,    0, 0, 0},
      '{KIND_QUERY_INDEX, 0,  0,  0, 16'd26,   1, 1, 1},
      '{KIND_QUERY_XYZ,   2,  2,  3, 16'd0,    1, 0, 0},
      '{KIND_MARK_XYZ,    0,  1,  1, 16'd0,    0, 0, 0},
      '{KIND_QUERY_INDEX, 0,  0,  0, 16'd0,    0, 0, 0},
      '{KIND_MARK_XYZ,    1,  1,  1, 16'd0,    0, 0, 0},
      '{KIND_QUERY_XYZ,   1,  0,  1, 16'd0,    0, 0, 0}
   };

   // sizes include zero and out-of-range values on each axis
   phase_type phases [] = '{
      '{2,  2,  2,  120,  0,  0,   0, 0},
      '{4,  3,  2,  120, 63,  0,   0, 0},
      '{3,  3,  3,   80,  0,  0, 400, 1},
      '{63, 1,  1,  100,  0, 63,   0, 0},
      '{1,  63, 2,  100, 17, 17,   0, 0},
      '{2,  2,  63, 100,  0,  0,   0, 0},
      '{0,  3,  3,   40, 63,  0,   0, 0},
      '{3,  0,  2,   30,  0, 63,   0, 0},
      '{3,  3,  0,   30, 17, 17,   0, 0},
      '{5,  4,  3,  110, 17, 17,   0, 0},
      '{1,  1,  1,   40,  0, 63,   0, 0},
      '{4,  4,  4,   80,  0,  0,   0, 0}
   };

   initial begin
      req_ch.valid = 1'b0;
      req_ch.kind = KIND_MARK_XYZ;
      req_ch.x = '0;
      req_ch.y = '0;
      req_ch.z = '0;
      req_ch.cell_index = '0;
      occ_map_ok = 1'b0;
      reg_x = 1;
      reg_y = 1;
      reg_z = 1;
      foreach (occ_bits[n]) occ_bits[n] = 1'b0;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed part
      write_sizes(3, 3, 3);
      foreach (directed_rows[r]) offer_item(directed_rows[r]);
      drain_results();

      // random phases
      foreach (phases[p]) begin
         write_sizes(phases[p].sx, phases[p].sy, phases[p].sz);
         send_idle_pct = phases[p].send_idle;
         recv_stall_pct = phases[p].recv_stall;
         if (phases[p].hold_cycles > 0) begin
            hold_len = phases[p].hold_cycles;
            hold_seq++;
         end
         for (int unsigned n = 0; n < phases[p].count; n++) begin
            if (phases[p].mid_drain && n == phases[p].count / 2) drain_results();
            offer_item(random_item());
         end
         drain_results();
      end

      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== grid_cell_occupancy_flood_fill.f =====
rtl/gcof_pkg.sv
rtl/gcof_if.sv
rtl/gcof_ram.sv
rtl/grid_cell_occupancy_flood_fill.sv
bench/tb_grid_cell_occupancy_flood_fill.sv
